// ===== hdl/jpeg_scan_bit_reader_defines.svh =====
// ----------------------------------------------------------------------------
// jpeg_scan_bit_reader_defines.svh
// Assertion macros used by the bit reader core (jsbr_core).
// ----------------------------------------------------------------------------
`ifndef JPEG_SCAN_BIT_READER_DEFINES_SVH
`define JPEG_SCAN_BIT_READER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define JSBR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsbr assertion failed");

// next-cycle implication
`define JSBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsbr assertion failed");

`endif

// ===== hdl/jsbr_pkg.sv =====
// ----------------------------------------------------------------------------
// jsbr_pkg
// Types and constants of the JPEG scan bit reader.
// ----------------------------------------------------------------------------
`default_nettype none

package jsbr_pkg;

  localparam int BUFFER_BITS    = 32;
  localparam int MAX_FIELD_BITS = 16;
  localparam int BYTE_BITS      = 8;
  localparam int CNT_W          = 6;
  localparam int N_W            = 5;
  localparam int FIELD_IDX_W    = $clog2(MAX_FIELD_BITS);
  localparam int VALUE_W        = 17;

  localparam logic [BYTE_BITS-1:0] STUFF_LEAD = 8'hFF;
  localparam logic [BYTE_BITS-1:0] STUFF_ZERO = 8'h00;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_FIELD = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_MARKER    = 2'd3
  } status_t;

  typedef struct packed {
    req_t                 req_type;
    logic [BYTE_BITS-1:0] data_byte;
    logic [N_W-1:0]       field_bits;
    logic                 signed_mode;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  value;
    logic [CNT_W-1:0]           bits_held;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/jsbr_core.sv =====
// ----------------------------------------------------------------------------
// jsbr_core
// Bit buffer state and the combinational byte append / field extract logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_scan_bit_reader_defines.svh"

module jsbr_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire jsbr_pkg::in_item_t item,
  input  wire logic              destuff_en,
  output jsbr_pkg::result_t      result
);

  localparam logic [jsbr_pkg::CNT_W-1:0] FULL_LIMIT =
    jsbr_pkg::CNT_W'(jsbr_pkg::BUFFER_BITS - jsbr_pkg::BYTE_BITS);
  localparam logic [jsbr_pkg::N_W-1:0] MAX_N = jsbr_pkg::N_W'(jsbr_pkg::MAX_FIELD_BITS);

  logic [jsbr_pkg::BUFFER_BITS-1:0] bit_buffer_r, bit_buffer_nxt;
  logic [jsbr_pkg::CNT_W-1:0]       bit_count_r, bit_count_nxt;
  logic                             stuff_pending_r, stuff_pending_nxt;

  logic [jsbr_pkg::N_W-1:0]            n;
  logic [jsbr_pkg::CNT_W-1:0]          rest;
  logic [jsbr_pkg::BUFFER_BITS-1:0]    keep_mask;
  logic [jsbr_pkg::BUFFER_BITS-1:0]    shifted;
  logic [jsbr_pkg::MAX_FIELD_BITS-1:0] field_mask;
  logic [jsbr_pkg::MAX_FIELD_BITS-1:0] raw;
  logic [jsbr_pkg::FIELD_IDX_W-1:0]    sign_idx;
  jsbr_pkg::status_t                   status;
  logic signed [jsbr_pkg::VALUE_W-1:0] value;

  assign n          = (item.field_bits > MAX_N) ? MAX_N : item.field_bits;
  assign rest       = bit_count_r - jsbr_pkg::CNT_W'(n);
  assign keep_mask  = ~({jsbr_pkg::BUFFER_BITS{1'b1}} << rest);
  assign shifted    = bit_buffer_r >> rest;
  assign field_mask = ~({jsbr_pkg::MAX_FIELD_BITS{1'b1}} << n);
  assign raw        = shifted[jsbr_pkg::MAX_FIELD_BITS-1:0] & field_mask;
  assign sign_idx   = jsbr_pkg::FIELD_IDX_W'(n - jsbr_pkg::N_W'(1));

  always_comb begin
    bit_buffer_nxt    = bit_buffer_r;
    bit_count_nxt     = bit_count_r;
    stuff_pending_nxt = stuff_pending_r;
    status            = jsbr_pkg::ST_OK;
    value             = '0;
    unique case (item.req_type)
      jsbr_pkg::REQ_BYTE: begin
        if (destuff_en && stuff_pending_r) begin
          stuff_pending_nxt = 1'b0;
          if (item.data_byte == jsbr_pkg::STUFF_ZERO) begin
            status = jsbr_pkg::ST_OK;
          end else begin
            status = jsbr_pkg::ST_MARKER;
          end
        end else if (bit_count_r > FULL_LIMIT) begin
          stuff_pending_nxt = 1'b0;
          status            = jsbr_pkg::ST_FULL;
        end else begin
          // bits above the count are always zero, so a plain shift suffices
          bit_buffer_nxt    = {bit_buffer_r[jsbr_pkg::BUFFER_BITS-jsbr_pkg::BYTE_BITS-1:0],
                               item.data_byte};
          bit_count_nxt     = bit_count_r + jsbr_pkg::CNT_W'(jsbr_pkg::BYTE_BITS);
          stuff_pending_nxt = destuff_en && (item.data_byte == jsbr_pkg::STUFF_LEAD);
        end
      end
      jsbr_pkg::REQ_FIELD: begin
        if (jsbr_pkg::CNT_W'(n) > bit_count_r) begin
          status = jsbr_pkg::ST_UNDERFLOW;
        end else if (n != '0) begin
          bit_count_nxt  = rest;
          bit_buffer_nxt = bit_buffer_r & keep_mask;
          if (item.signed_mode && !raw[sign_idx]) begin
            value = {1'b0, raw} - {1'b0, field_mask};
          end else begin
            value = {1'b0, raw};
          end
        end
      end
      default: begin
        status = jsbr_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buffer_r    <= '0;
      bit_count_r     <= '0;
      stuff_pending_r <= 1'b0;
    end else if (step) begin
      bit_buffer_r    <= bit_buffer_nxt;
      bit_count_r     <= bit_count_nxt;
      stuff_pending_r <= stuff_pending_nxt;
    end
  end

  assign result.status    = status;
  assign result.value     = value;
  assign result.bits_held = bit_count_nxt;

  `JSBR_ASSERT_IMPL(a_count_range, 1'b1,
                    bit_count_r <= jsbr_pkg::CNT_W'(jsbr_pkg::BUFFER_BITS))
  `JSBR_ASSERT_IMPL(a_clean_upper, 1'b1, (bit_buffer_r >> bit_count_r) == '0)
  `JSBR_ASSERT_NEXT(a_underflow_keeps, step && status == jsbr_pkg::ST_UNDERFLOW,
                    $stable(bit_count_r) && $stable(bit_buffer_r))
  `JSBR_ASSERT_NEXT(a_full_keeps, step && status == jsbr_pkg::ST_FULL,
                    $stable(bit_count_r) && !stuff_pending_r)

endmodule

`default_nettype wire

// ===== hdl/jpeg_scan_bit_reader.sv =====
// ----------------------------------------------------------------------------
// jpeg_scan_bit_reader
// MSB-first bit reader for JPEG scan data with 0xFF00 destuffing.
// ----------------------------------------------------------------------------
// Pipeline: an input transaction is captured in the input register, then its
//   result in the result register, which drives out_tvalid.
// Throughput: one transaction per cycle unless out_tready stalls; the bit buffer updates on each step.
// Reset (rst_n low, synchronous): buffer empty, no stuff byte pending,
//   destuffing enabled, both pipeline registers empty.
`default_nettype none

module jpeg_scan_bit_reader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // data_byte[7:0], field_bits[12:8], signed_mode[13]
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // value[16:0], bits_held[22:17]
  output logic [1:0]       out_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // destuff_enable
);

  logic               destuff_r;
  logic               in_valid_r, in_valid_nxt;
  jsbr_pkg::in_item_t in_item_r;
  logic               out_valid_r, out_valid_nxt;
  jsbr_pkg::result_t  out_res_r;
  jsbr_pkg::result_t  core_res;
  logic               adv;
  logic               step;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign step      = in_valid_r && adv;

  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = adv ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      destuff_r   <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        destuff_r <= cfg_data;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type    <= jsbr_pkg::req_t'(in_tuser);
      in_item_r.data_byte   <= in_tdata[7:0];
      in_item_r.field_bits  <= in_tdata[12:8];
      in_item_r.signed_mode <= in_tdata[13];
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  jsbr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (in_item_r),
    .destuff_en (destuff_r),
    .result     (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.bits_held, out_res_r.value};
  assign out_tuser  = out_res_r.status;

endmodule

`default_nettype wire
